// File: hdl/rpwf_pkg.sv
package rpwf_pkg;

  localparam int NUM_CH          = 3;
  localparam int VAL_W           = 8;
  localparam int REF_W           = 10;
  localparam int OUT_POS_W       = 12;
  localparam int SLOPE_W         = 32;
  localparam int ICPT_W          = 48;
  localparam int FRAC_BITS       = 16;
  localparam int MAX_PIXELS_DEF  = 4096;
  localparam int POS_W_DEF       = $clog2(MAX_PIXELS_DEF);

  // divider widths for the default line length
  localparam int DIV_DW_DEF      = 2 * POS_W_DEF + 4;
  localparam int DIV_NW_RAW_DEF  = 2 * POS_W_DEF + REF_W + 4 + FRAC_BITS;
  localparam int DIV_NW_DEF      = (DIV_NW_RAW_DEF > ICPT_W + 1) ? DIV_NW_RAW_DEF : ICPT_W + 1;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_REF_CH0 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REF_CH1 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REF_CH2 = 2'd2;

  localparam logic [REF_W-1:0] REF_CH0_RST = 10'd468;
  localparam logic [REF_W-1:0] REF_CH1_RST = 10'd535;
  localparam logic [REF_W-1:0] REF_CH2_RST = 10'd620;

  // status codes
  localparam logic [1:0] STATUS_OK         = 2'd0;
  localparam logic [1:0] STATUS_NO_PEAK    = 2'd1;
  localparam logic [1:0] STATUS_DEGENERATE = 2'd2;

  typedef struct packed {
    logic [VAL_W-1:0] chan0_value;
    logic [VAL_W-1:0] chan1_value;
    logic [VAL_W-1:0] chan2_value;
    logic             last_pixel;
  } pixel_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [SLOPE_W-1:0] slope;
    logic signed [ICPT_W-1:0]  intercept;
    logic [OUT_POS_W-1:0]     peak_pos_ch0;
    logic [OUT_POS_W-1:0]     peak_pos_ch1;
    logic [OUT_POS_W-1:0]     peak_pos_ch2;
  } result_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic clear;
  } fit_ctl_t;

  typedef enum logic [3:0] {
    FIT_IDLE,
    FIT_LANE,
    FIT_SUM,
    FIT_MUL,
    FIT_DIFF,
    FIT_CHECK,
    FIT_DIV_SLOPE,
    FIT_DIV_ICPT,
    FIT_DONE
  } fit_state_t;

endpackage

// File: hdl/rpwf_lane.sv
module rpwf_lane import rpwf_pkg::*; #(
  parameter int PW = POS_W_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               take,
  input  logic               clear,
  input  logic               in_range,
  input  logic [VAL_W-1:0]   value,
  input  logic [PW-1:0]      index,
  input  logic [REF_W-1:0]   ref_wl,
  output logic               nonzero,
  output logic [PW-1:0]      pos,
  output logic [2*PW-1:0]    sq,
  output logic [PW+REF_W-1:0] xy
);

  logic [VAL_W-1:0] peak;

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      peak <= '0;
      pos  <= '0;
    end else if (take && in_range && (value > peak)) begin
      peak <= value;
      pos  <= index;
    end
  end

  // products are registered from the stored position, in the cycle after it changes
  always_ff @(posedge clk) begin
    sq <= (2*PW)'(pos) * (2*PW)'(pos);
    xy <= (PW+REF_W)'(pos) * (PW+REF_W)'(ref_wl);
  end

  assign nonzero = (peak != '0);

endmodule

// File: hdl/rpwf_div.sv
module rpwf_div import rpwf_pkg::*; #(
  parameter int NW = DIV_NW_DEF,
  parameter int DW = DIV_DW_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [NW-1:0] quotient
);

  localparam int CNTW = $clog2(NW);

  logic            active;
  logic [CNTW-1:0] cnt;
  logic [NW-1:0]   dvd;
  logic [DW-1:0]   den;
  logic [DW-1:0]   rem;
  logic [DW:0]     trial;
  logic [DW:0]     diff;
  logic            ge;
  logic [DW-1:0]   rem_next;

  // restoring step, one quotient bit per cycle
  always_comb begin
    trial    = {rem, dvd[NW-1]};
    diff     = trial - {1'b0, den};
    ge       = (trial >= {1'b0, den});
    rem_next = ge ? diff[DW-1:0] : trial[DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= active && (cnt == '0);
      if (start) begin
        active <= 1'b1;
        cnt    <= CNTW'(NW - 1);
      end else if (active) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          active <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      den <= divisor;
      rem <= '0;
    end else if (active) begin
      dvd      <= {dvd[NW-2:0], 1'b0};
      rem      <= rem_next;
      quotient <= {quotient[NW-2:0], ge};
    end
  end

endmodule

// File: hdl/rpwf_fit.sv
module rpwf_fit import rpwf_pkg::*; #(
  parameter int PW = POS_W_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            go,
  input  logic [NUM_CH-1:0]               nz,
  input  logic [NUM_CH-1:0][PW-1:0]       pos,
  input  logic [NUM_CH-1:0][2*PW-1:0]     sq,
  input  logic [NUM_CH-1:0][PW+REF_W-1:0] xy,
  input  logic [NUM_CH-1:0][REF_W-1:0]    ref_wl,
  output fit_ctl_t                        ctl,
  output result_t                         result
);

  localparam int SXW   = PW + 2;
  localparam int SYW   = REF_W + 2;
  localparam int SXXW  = 2 * PW + 2;
  localparam int SXYW  = PW + REF_W + 2;
  localparam int DW    = 2 * PW + 4;
  localparam int PSW   = SXW + SYW;
  localparam int PIW   = SXXW + SYW;
  localparam int NSW   = PSW + 1;
  localparam int NIW   = PIW + 1;
  localparam int NWRAW = PIW + FRAC_BITS;
  localparam int NW    = (NWRAW > ICPT_W + 1) ? NWRAW : ICPT_W + 1;
  localparam int EW    = (PW > OUT_POS_W) ? PW : OUT_POS_W;

  localparam logic [NW-1:0] SLOPE_LIM  = NW'({1'b0, {(SLOPE_W-1){1'b1}}});
  localparam logic [NW-1:0] SLOPE_LIM1 = SLOPE_LIM + NW'(1);
  localparam logic [NW-1:0] ICPT_LIM   = NW'({1'b0, {(ICPT_W-1){1'b1}}});
  localparam logic [NW-1:0] ICPT_LIM1  = ICPT_LIM + NW'(1);

  fit_state_t state, state_next;

  logic [SXW-1:0]  sx, sx_c;
  logic [SYW-1:0]  sy, sy_c;
  logic [SXXW-1:0] sxx, sxx_c;
  logic [SXYW-1:0] sxy, sxy_c;
  logic            nopeak;
  logic [DW-1:0]   p_sxsx;
  logic [PSW-1:0]  p_sxsy;
  logic [PIW-1:0]  p_sxxsy;
  logic [PIW-1:0]  p_sxsxy;
  logic [DW-1:0]   den;
  logic [NSW-1:0]  num_s, abs_s;
  logic [NIW-1:0]  num_i, abs_i;
  logic            neg_s, neg_i;
  logic [NSW-2:0]  mag_s;
  logic [NIW-2:0]  mag_i;

  logic            div_start, div_done;
  logic [NW-1:0]   div_dvd, div_q;

  logic [NW-1:0]        slope_mag, icpt_mag;
  logic [SLOPE_W-1:0]   slope_lo, slope_val;
  logic [ICPT_W-1:0]    icpt_lo, icpt_val;
  logic [1:0]           status_r;
  logic [SLOPE_W-1:0]   slope_r;
  logic [ICPT_W-1:0]    icpt_r;
  logic [NUM_CH-1:0][EW-1:0] pos_ext;

  // merge sums over the lanes
  always_comb begin
    sx_c  = '0;
    sy_c  = '0;
    sxx_c = '0;
    sxy_c = '0;
    for (int c = 0; c < NUM_CH; c++) begin
      sx_c  = sx_c  + SXW'(pos[c]);
      sy_c  = sy_c  + SYW'(ref_wl[c]);
      sxx_c = sxx_c + SXXW'(sq[c]);
      sxy_c = sxy_c + SXYW'(xy[c]);
    end
  end

  // numerators: 3*Sxy - Sx*Sy and Sxx*Sy - Sx*Sxy
  always_comb begin
    num_s = NSW'(sxy) + NSW'({sxy, 1'b0}) - NSW'(p_sxsy);
    num_i = NIW'(p_sxxsy) - NIW'(p_sxsxy);
    abs_s = num_s[NSW-1] ? (~num_s + NSW'(1)) : num_s;
    abs_i = num_i[NIW-1] ? (~num_i + NIW'(1)) : num_i;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FIT_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      FIT_IDLE:      if (go) state_next = FIT_LANE;
      FIT_LANE:      state_next = FIT_SUM;
      FIT_SUM:       state_next = FIT_MUL;
      FIT_MUL:       state_next = FIT_DIFF;
      FIT_DIFF:      state_next = FIT_CHECK;
      FIT_CHECK:     state_next = (nopeak || den == '0) ? FIT_DONE : FIT_DIV_SLOPE;
      FIT_DIV_SLOPE: if (div_done) state_next = FIT_DIV_ICPT;
      FIT_DIV_ICPT:  if (div_done) state_next = FIT_DONE;
      FIT_DONE:      state_next = FIT_IDLE;
      default:       state_next = FIT_IDLE;
    endcase
  end

  always_comb begin
    ctl.busy  = (state != FIT_IDLE);
    ctl.done  = (state == FIT_DONE);
    ctl.clear = (state == FIT_DONE);
    div_start = ((state == FIT_CHECK) && !nopeak && (den != '0)) ||
                ((state == FIT_DIV_SLOPE) && div_done);
  end

  assign div_dvd = (state == FIT_DIV_SLOPE) ? NW'({mag_i, {FRAC_BITS{1'b0}}})
                                            : NW'({mag_s, {FRAC_BITS{1'b0}}});

  rpwf_div #(
    .NW(NW),
    .DW(DW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (den),
    .done     (div_done),
    .quotient (div_q)
  );

  // clamp the quotient magnitude, then apply the sign
  always_comb begin
    if (neg_s) begin
      slope_mag = (div_q > SLOPE_LIM1) ? SLOPE_LIM1 : div_q;
    end else begin
      slope_mag = (div_q > SLOPE_LIM) ? SLOPE_LIM : div_q;
    end
    if (neg_i) begin
      icpt_mag = (div_q > ICPT_LIM1) ? ICPT_LIM1 : div_q;
    end else begin
      icpt_mag = (div_q > ICPT_LIM) ? ICPT_LIM : div_q;
    end
    slope_lo  = slope_mag[SLOPE_W-1:0];
    icpt_lo   = icpt_mag[ICPT_W-1:0];
    slope_val = neg_s ? (~slope_lo + SLOPE_W'(1)) : slope_lo;
    icpt_val  = neg_i ? (~icpt_lo + ICPT_W'(1)) : icpt_lo;
  end

  always_ff @(posedge clk) begin
    case (state)
      FIT_SUM: begin
        sx     <= sx_c;
        sy     <= sy_c;
        sxx    <= sxx_c;
        sxy    <= sxy_c;
        nopeak <= !(&nz);
      end
      FIT_MUL: begin
        p_sxsx  <= DW'(sx) * DW'(sx);
        p_sxsy  <= PSW'(sx) * PSW'(sy);
        p_sxxsy <= PIW'(sxx) * PIW'(sy);
        p_sxsxy <= PIW'(sx) * PIW'(sxy);
      end
      FIT_DIFF: begin
        den   <= DW'(sxx) + DW'({sxx, 1'b0}) - p_sxsx;
        neg_s <= num_s[NSW-1];
        neg_i <= num_i[NIW-1];
        mag_s <= abs_s[NSW-2:0];
        mag_i <= abs_i[NIW-2:0];
      end
      FIT_CHECK: begin
        slope_r <= '0;
        icpt_r  <= '0;
        if (nopeak) begin
          status_r <= STATUS_NO_PEAK;
        end else if (den == '0) begin
          status_r <= STATUS_DEGENERATE;
        end else begin
          status_r <= STATUS_OK;
        end
      end
      FIT_DIV_SLOPE: if (div_done) slope_r <= slope_val;
      FIT_DIV_ICPT:  if (div_done) icpt_r <= icpt_val;
      default: ;
    endcase
  end

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      pos_ext[c] = EW'(pos[c]);
    end
    result.status       = status_r;
    result.slope        = slope_r;
    result.intercept    = icpt_r;
    result.peak_pos_ch0 = pos_ext[0][OUT_POS_W-1:0];
    result.peak_pos_ch1 = pos_ext[1][OUT_POS_W-1:0];
    result.peak_pos_ch2 = pos_ext[2][OUT_POS_W-1:0];
  end

endmodule

// File: hdl/rgb_peak_wavelength_fit_top.sv
// Channel   Ports                          Dir  Handshake
// pixel     start, busy, pixel (pixel_t)   in   taken when start && !busy
// result    done, result (result_t)        out  one-cycle strobe on done
// config    cfg_we, cfg_index, cfg_data    in   written when cfg_we is high
//
// Pixels go in one per cycle while busy is low. A pixel with last_pixel set
// starts the line fit; busy then stays high until the result strobe. With a
// valid fit the restoring divider runs over NW = max(2*PW+30, 49) bits,
// once for the slope and once for the intercept. No-peak and degenerate
// lines skip both divisions and report straight after the check state.
// rst is synchronous: line state clears, wavelengths go to 468/535/620 nm.
// done is a plain strobe; the receiver has no way to stall it.
module rgb_peak_wavelength_fit_top import rpwf_pkg::*; #(
  parameter int MAX_PIXELS = MAX_PIXELS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  pixel_t               pixel,
  output logic                 done,
  output result_t              result,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REF_W-1:0]     cfg_data
);

  // position width holds the last index, count width holds MAX_PIXELS
  localparam int PW = $clog2(MAX_PIXELS);
  localparam int CW = $clog2(MAX_PIXELS + 1);

  logic                            accept;
  logic                            in_range;
  logic [CW-1:0]                   pixel_count;
  logic [NUM_CH-1:0][REF_W-1:0]    ref_wl;
  logic [NUM_CH-1:0][VAL_W-1:0]    chan_val;
  logic [NUM_CH-1:0]               nz;
  logic [NUM_CH-1:0][PW-1:0]       pos;
  logic [NUM_CH-1:0][2*PW-1:0]     sq;
  logic [NUM_CH-1:0][PW+REF_W-1:0] xy;
  fit_ctl_t                        ctl;

  assign accept   = start && !ctl.busy;
  assign in_range = (pixel_count < CW'(MAX_PIXELS));
  assign busy     = ctl.busy;
  assign done     = ctl.done;

  assign chan_val[0] = pixel.chan0_value;
  assign chan_val[1] = pixel.chan1_value;
  assign chan_val[2] = pixel.chan2_value;

  // reference wavelengths; an index past the list is dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      ref_wl[0] <= REF_CH0_RST;
      ref_wl[1] <= REF_CH1_RST;
      ref_wl[2] <= REF_CH2_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_REF_CH0: ref_wl[0] <= cfg_data;
        REG_REF_CH1: ref_wl[1] <= cfg_data;
        REG_REF_CH2: ref_wl[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // pixel index within the line, holds at the bound
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      pixel_count <= '0;
    end else if (accept && in_range) begin
      pixel_count <= pixel_count + 1'b1;
    end
  end

  // one peak tracker per color channel
  for (genvar c = 0; c < NUM_CH; c++) begin : g_lane
    rpwf_lane #(
      .PW(PW)
    ) u_lane (
      .clk      (clk),
      .rst      (rst),
      .take     (accept),
      .clear    (ctl.clear),
      .in_range (in_range),
      .value    (chan_val[c]),
      .index    (pixel_count[PW-1:0]),
      .ref_wl   (ref_wl[c]),
      .nonzero  (nz[c]),
      .pos      (pos[c]),
      .sq       (sq[c]),
      .xy       (xy[c])
    );
  end

  // merge: sums over lanes, line fit, division and saturation
  rpwf_fit #(
    .PW(PW)
  ) u_fit (
    .clk    (clk),
    .rst    (rst),
    .go     (accept && pixel.last_pixel),
    .nz     (nz),
    .pos    (pos),
    .sq     (sq),
    .xy     (xy),
    .ref_wl (ref_wl),
    .ctl    (ctl),
    .result (result)
  );

endmodule
